FILE: hw/rtl/segment_mean_variance_normalizer_macros.svh
// Assertion macros for the segment normalizer.
`ifndef SEGMENT_MEAN_VARIANCE_NORMALIZER_MACROS_SVH
`define SEGMENT_MEAN_VARIANCE_NORMALIZER_MACROS_SVH
`ifndef SYNTHESIS
`define SMVN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SMVN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SMVN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SMVN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/smvn_pkg.sv
// ----------------------------------------------------------------------------
// smvn_pkg
// Shared types and constants of the segment normalizer.
// ----------------------------------------------------------------------------
package smvn_pkg;
    localparam int MaxSegmentDefault = 64;
    localparam int StoreDepth        = 64;
    localparam logic [15:0] EpsilonReset = 16'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;       // reset the sum accumulator after a segment
        logic load;        // store accepted sample
        logic mean_start;  // start mean division
        logic var_acc;     // accumulate one squared deviation
        logic var_start;   // start variance division
        logic sqrt_start;  // start root
        logic norm_start;  // start one normalize division
        logic rd_en;       // read store at rd_addr
        logic [5:0] rd_addr;
    } smvn_cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
    } smvn_stat_t;
endpackage

FILE: hw/rtl/smvn_if.sv
// ----------------------------------------------------------------------------
// smvn_in_if / smvn_out_if / smvn_cfg_if
// Valid/ready channels of the segment normalizer.
// ----------------------------------------------------------------------------
interface smvn_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] sample;
    logic last_in_segment;
    modport source (output valid, sample, last_in_segment, input ready);
    modport sink (input valid, sample, last_in_segment, output ready);
endinterface

interface smvn_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] normalized;
    logic [15:0] sigma;
    logic last_result;
    modport source (output valid, normalized, sigma, last_result, input ready);
    modport sink (input valid, normalized, sigma, last_result, output ready);
endinterface

interface smvn_cfg_if;
    logic valid;
    logic ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/smvn_divider.sv
// ----------------------------------------------------------------------------
// smvn_divider
// Restoring divider, one quotient bit per cycle, 40-bit magnitudes.
// ----------------------------------------------------------------------------
module smvn_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] num,
    input  logic [39:0] den,
    output logic        busy,
    output logic [39:0] quo
);
    logic [39:0] rem_reg, rem_next;
    logic [39:0] q_reg, q_next;
    logic [39:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [40:0] trial;

    // One shift-subtract step per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, q_reg[39]} - {1'b0, den_reg};
        if (start)
        begin
            rem_next  = '0;
            q_next    = num;
            den_next  = den;
            cnt_next  = 6'd40;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[40])
            begin
                rem_next = trial[39:0];
                q_next   = {q_reg[38:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[38:0], q_reg[39]};
                q_next   = {q_reg[38:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = q_reg;
endmodule

FILE: hw/rtl/smvn_sqrt.sv
// ----------------------------------------------------------------------------
// smvn_sqrt
// Digit-by-digit square root of a 40-bit value, rounded to nearest.
// ----------------------------------------------------------------------------
module smvn_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] value,
    output logic        busy,
    output logic [15:0] root
);
    logic [39:0] v_reg, v_next;
    logic [39:0] r_reg, r_next;
    logic [39:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic [20:0] rounded;

    // One result bit per cycle; bit walks down by four.
    always_comb
    begin
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (start)
        begin
            v_next    = value;
            r_next    = '0;
            bit_next  = 40'h40_0000_0000;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= r_reg + bit_reg)
            begin
                v_next = v_reg - (r_reg + bit_reg);
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    // Round to nearest and saturate.
    assign rounded = r_reg[20:0] + ((v_reg > r_reg) ? 21'd1 : 21'd0);
    assign busy    = busy_reg;
    assign root    = (rounded > 21'd65535) ? 16'hFFFF : rounded[15:0];
endmodule

FILE: hw/rtl/smvn_datapath.sv
// ----------------------------------------------------------------------------
// smvn_datapath
// Sample store, accumulators, shared divider and root unit.
// ----------------------------------------------------------------------------
module smvn_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  smvn_pkg::smvn_cmd_t cmd,
    input  logic [6:0]          count,
    input  logic signed [15:0]  sample,
    input  logic [5:0]          wr_addr,
    input  logic [15:0]         epsilon,
    output smvn_pkg::smvn_stat_t stat,
    output logic signed [15:0]  normalized,
    output logic [15:0]         sigma
);
    import smvn_pkg::*;

    logic [15:0]        store [StoreDepth];
    logic signed [15:0] rd_reg;
    logic signed [21:0] sum_reg, sum_next;
    logic [37:0]        sq_reg, sq_next;
    logic signed [15:0] mean_reg, mean_next;
    logic [15:0]        sigma_reg, sigma_next;
    logic               neg_reg, neg_next;
    logic               last_div_reg;
    logic               last_sq_reg;
    logic signed [17:0] dev;
    logic [17:0]        dev_mag;
    logic [35:0]        dev_sq;
    logic [39:0]        div_num, div_den, quo;
    logic               div_busy, sqrt_busy;
    logic [15:0]        root;
    logic [39:0]        sqrt_in;
    logic [21:0]        sum_mag;
    logic               any_start;
    logic [1:0]         sel_reg, sel_next;

    localparam logic [1:0] SelMean = 2'd0, SelVar = 2'd1, SelNorm = 2'd2;

    // Sample store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            store[wr_addr] <= sample;
        end
        if (cmd.rd_en)
        begin
            rd_reg <= store[cmd.rd_addr];
        end
    end

    assign dev     = 18'(rd_reg) - 18'(mean_reg);
    assign dev_mag = dev[17] ? 18'(-dev) : dev;
    assign sum_mag = sum_reg[21] ? 22'(-sum_reg) : sum_reg;
    assign any_start = cmd.mean_start | cmd.var_start | cmd.norm_start;

    // Divider operand select.
    always_comb
    begin
        div_num  = '0;
        div_den  = 40'(count);
        neg_next = neg_reg;
        sel_next = sel_reg;
        if (cmd.mean_start)
        begin
            div_num  = 40'(sum_mag) + 40'(count[6:1]);
            neg_next = sum_reg[21];
            sel_next = SelMean;
        end
        else if (cmd.var_start)
        begin
            div_num  = 40'(sq_reg) + 40'(count[6:1]);
            sel_next = SelVar;
        end
        else if (cmd.norm_start)
        begin
            div_num  = {10'd0, dev_mag, 12'd0} + 40'(sigma_reg[15:1]);
            div_den  = 40'(sigma_reg);
            neg_next = dev[17];
            sel_next = SelNorm;
        end
    end

    smvn_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(any_start),
        .num(div_num), .den(div_den), .busy(div_busy), .quo(quo)
    );

    assign sqrt_in = quo + 40'(epsilon);

    smvn_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(cmd.sqrt_start),
        .value(sqrt_in), .busy(sqrt_busy), .root(root)
    );

    // Accumulator updates.
    always_comb
    begin
        sum_next   = sum_reg;
        sq_next    = sq_reg;
        mean_next  = mean_reg;
        sigma_next = sigma_reg;
        dev_sq     = dev_mag * dev_mag;
        if (cmd.load)
        begin
            sum_next = sum_reg + 22'(sample);
        end
        if (cmd.var_acc)
        begin
            sq_next = sq_reg + 38'(dev_sq);
        end
        if (cmd.mean_start)
        begin
            sq_next = '0;
        end
        if (last_div_reg && !div_busy && sel_reg == SelMean)
        begin
            mean_next = neg_reg ? 16'(-quo[15:0]) : quo[15:0];
        end
        if (cmd.sqrt_start)
        begin
            sigma_next = 16'd0;
        end
        if (!sqrt_busy && cmd.norm_start == 1'b0 && cmd.clear == 1'b0)
        begin
            sigma_next = sigma_next;
        end
        if (cmd.clear)
        begin
            sum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            sq_reg       <= '0;
            mean_reg     <= '0;
            sigma_reg    <= '0;
            neg_reg      <= 1'b0;
            sel_reg      <= SelMean;
            last_div_reg <= 1'b0;
        end
        else
        begin
            sum_reg      <= sum_next;
            sq_reg       <= sq_next;
            mean_reg     <= mean_next;
            sigma_reg    <= (last_sq_reg && !sqrt_busy) ? root : sigma_next;
            neg_reg      <= neg_next;
            sel_reg      <= sel_next;
            last_div_reg <= div_busy;
        end
    end

    // Track falling edge of the root unit for the sigma capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sq_reg <= 1'b0;
        end
        else
        begin
            last_sq_reg <= sqrt_busy;
        end
    end

    // Normalized result with saturation and the zero-sigma case.
    always_comb
    begin
        if (sigma_reg == 16'd0)
        begin
            normalized = neg_reg ? -16'sd32768 :
                         ((dev != 18'sd0) ? 16'sd32767 : 16'sd0);
        end
        else if (neg_reg)
        begin
            normalized = (quo > 40'd32768) ? -16'sd32768 : 16'(-quo[15:0]);
        end
        else
        begin
            normalized = (quo > 40'd32767) ? 16'sd32767 : quo[15:0];
        end
    end

    assign sigma          = sigma_reg;
    assign stat.div_busy  = div_busy;
    assign stat.sqrt_busy = sqrt_busy;
endmodule

FILE: hw/rtl/smvn_ctrl.sv
// ----------------------------------------------------------------------------
// smvn_ctrl
// Sequencer: load, mean, variance pass, root, normalize-and-emit pass.
// ----------------------------------------------------------------------------
module smvn_ctrl #(
    parameter int MAX_SEGMENT = smvn_pkg::MaxSegmentDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_last,
    input  smvn_pkg::smvn_stat_t stat,
    output smvn_pkg::smvn_cmd_t  cmd,
    output logic [6:0]           count,
    output logic [5:0]           wr_addr
);
    import smvn_pkg::*;

    typedef enum logic [9:0] {
        S_LOAD   = 10'b00_0000_0001,
        S_MEAN   = 10'b00_0000_0010,
        S_VRD    = 10'b00_0000_0100,
        S_VACC   = 10'b00_0000_1000,
        S_VDIV   = 10'b00_0001_0000,
        S_SQRT   = 10'b00_0010_0000,
        S_NRD    = 10'b00_0100_0000,
        S_NDIV   = 10'b00_1000_0000,
        S_EMIT   = 10'b01_0000_0000,
        S_WAIT   = 10'b10_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [6:0] idx_reg, idx_next;
    logic       go_reg, go_next;
    logic       accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        go_next    = 1'b0;
        cmd        = '0;
        cmd.rd_addr = idx_reg[5:0];
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    cnt_next = cnt_reg + 7'd1;
                    if (in_last || cnt_reg == 7'(MAX_SEGMENT - 1))
                    begin
                        state_next = S_MEAN;
                        go_next    = 1'b1;
                    end
                end
            end
            S_MEAN:
            begin
                // Strobe the start for one cycle, then wait for the quotient.
                if (go_reg)
                begin
                    cmd.mean_start = 1'b1;
                end
                else if (!stat.div_busy)
                begin
                    idx_next   = '0;
                    state_next = S_VRD;
                end
            end
            S_VRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_VACC;
            end
            S_VACC:
            begin
                cmd.var_acc = 1'b1;
                idx_next    = idx_reg + 7'd1;
                if (idx_reg + 7'd1 == cnt_reg)
                begin
                    state_next = S_VDIV;
                    go_next    = 1'b1;
                end
                else
                begin
                    state_next = S_VRD;
                end
            end
            S_VDIV:
            begin
                if (go_reg)
                begin
                    cmd.var_start = 1'b1;
                end
                else if (!stat.div_busy)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT;
                    go_next        = 1'b1;
                end
            end
            S_SQRT:
            begin
                if (!go_reg && !stat.sqrt_busy)
                begin
                    idx_next   = '0;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_NRD;
            end
            S_NRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_NDIV;
                go_next    = 1'b1;
            end
            S_NDIV:
            begin
                if (go_reg)
                begin
                    cmd.norm_start = 1'b1;
                end
                else if (!stat.div_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 7'd1;
                    if (idx_reg + 7'd1 == cnt_reg)
                    begin
                        cmd.clear  = 1'b1;
                        cnt_next   = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_NRD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            go_reg    <= go_next;
        end
    end

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_EMIT);
    assign out_last  = (idx_reg + 7'd1 == cnt_reg);
    assign count     = cnt_reg;
    assign wr_addr   = cnt_reg[5:0];
endmodule

FILE: hw/rtl/segment_mean_variance_normalizer.sv
// ----------------------------------------------------------------------------
// segment_mean_variance_normalizer
// Layer normalization without affine terms over segments of Q8.8 samples.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// in_ch     sink       sample, last_in_segment
// out_ch    source     normalized, sigma, last_result
// cfg_ch    sink       data (epsilon)
//
// Loading accepts one sample per cycle. After the last sample come the mean
// division, a variance pass over the store, the variance division, the root
// and one idle state, then per result a read, a normalize division and the
// emit; one 40-step divider is shared. Reset is asynchronous and needs no
// clearing pass. A stalled result holds until taken; input waits meanwhile.
`include "segment_mean_variance_normalizer_macros.svh"
module segment_mean_variance_normalizer #(
    parameter int MAX_SEGMENT = smvn_pkg::MaxSegmentDefault
) (
    input logic       clk,
    input logic       rst_n,
    smvn_in_if.sink   in_ch,
    smvn_out_if.source out_ch,
    smvn_cfg_if.sink  cfg_ch
);
    import smvn_pkg::*;

    logic [15:0] epsilon_reg;
    smvn_cmd_t   cmd;
    smvn_stat_t  stat;
    logic [6:0]  count;
    logic [5:0]  wr_addr;

    // Epsilon register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= EpsilonReset;
        end
        else if (cfg_ch.valid)
        begin
            epsilon_reg <= cfg_ch.data;
        end
    end
    assign cfg_ch.ready = 1'b1;

    smvn_ctrl #(.MAX_SEGMENT(MAX_SEGMENT)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_last(in_ch.last_in_segment),
        .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_last(out_ch.last_result),
        .stat(stat), .cmd(cmd), .count(count), .wr_addr(wr_addr)
    );

    smvn_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .count(count),
        .sample(in_ch.sample), .wr_addr(wr_addr), .epsilon(epsilon_reg),
        .stat(stat), .normalized(out_ch.normalized), .sigma(out_ch.sigma)
    );

    // Never accept input while a result is on offer.
    `SMVN_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_ch.valid, !in_ch.ready)
    // A stalled result holds its value.
    `SMVN_ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(out_ch.normalized))
    // The root never runs while the divider does.
    `SMVN_ASSERT_IMPL(a_units, clk, rst_n, stat.sqrt_busy, !stat.div_busy)
endmodule
